// ----- rtl/nspc_pkg.sv -----
// shared types and constants for the nmea sentence pair capture block
// no dependencies
`default_nettype none

package nspc_pkg;

    localparam int TAG_LEN = 6;
    localparam int TAG_W = 8 * TAG_LEN;
    localparam int CNT_W = 3;
    localparam int IDX_W = 9;

    localparam logic [7:0] START_CHAR = 8'h24;
    localparam logic [IDX_W-1:0] CAPTURE_LIMIT = 9'd300;
    localparam logic [IDX_W-1:0] INDEX_START = IDX_W'(TAG_LEN);
    localparam logic [CNT_W-1:0] TAG_FULL = CNT_W'(TAG_LEN);

    // reset tags: "$GNRMC" and "$GNVTG"
    localparam logic [TAG_W-1:0] FIRST_TAG_RESET = 48'h24474E524D43;
    localparam logic [TAG_W-1:0] SECOND_TAG_RESET = 48'h24474E565447;

    // register map, selected by paddr[3]
    localparam logic REG_FIRST_TAG = 1'b0;
    localparam logic REG_SECOND_TAG = 1'b1;

    localparam int OUT_W = 1 + IDX_W + 8 + 1 + TAG_W + 1 + 1;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic              second_found;
        logic              first_locked;
        logic [TAG_W-1:0]  header_word;
        logic              header_write;
        logic [7:0]        body_byte;
        logic [IDX_W-1:0]  body_index;
        logic              body_write;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/nmea_sentence_pair_capture.sv -----
// top level: stream channels, apb tag registers and the result register
// depends on nspc_pkg and nspc_core
//
// usage:
//   s_tvalid/s_tready/s_tdata carry one received serial byte per transaction.
//   m_tvalid/m_tready/m_tdata return exactly one result per input byte.
//   the apb port holds first_tag at address 0x0 and second_tag at 0x8
//   (48 bits in pwdata/prdata [47:0]); write them only while the block idles.
// timing:
//   a byte accepted at one edge has its result valid on m_tdata right after
//   it. one byte per cycle is sustained while m_tready is high, set by the
//   single result register; the tag compare is a parallel 48-bit equality.
// stalls:
//   while m_tready is low a held result stays put and s_tready drops; a new
//   byte is taken in the same cycle the held result leaves.
// reset:
//   rst_n clears lock, found and the tag counter, sets the capture index to
//   six, empties the result register and restores the default tags.
`default_nettype none

module nmea_sentence_pair_capture (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] rx_byte
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // [0] body_write, [9:1] body_index, [17:10] body_byte, [18] header_write,
    // [66:19] header_word, [67] first_locked, [68] second_found, rest zero
    output      logic [nspc_pkg::OUT_BYTES_W-1:0] m_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [3:0]                       paddr,
    input  wire logic [63:0]                      pwdata,
    output      logic [63:0]                      prdata,
    output      logic                             pready
);
    import nspc_pkg::*;

    logic [TAG_W-1:0] first_tag_reg;
    logic [TAG_W-1:0] second_tag_reg;
    logic             out_valid_reg;
    result_t          out_data_reg;
    result_t          result;
    logic             accept;
    logic             cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3])
            REG_FIRST_TAG:  prdata = {{(64 - TAG_W){1'b0}}, first_tag_reg};
            REG_SECOND_TAG: prdata = {{(64 - TAG_W){1'b0}}, second_tag_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_tag_reg <= FIRST_TAG_RESET;
            second_tag_reg <= SECOND_TAG_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == REG_FIRST_TAG)
            begin
                first_tag_reg <= pwdata[TAG_W-1:0];
            end
            else
            begin
                second_tag_reg <= pwdata[TAG_W-1:0];
            end
        end
    end

    // a byte enters when the result register is empty or drains this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;

    nspc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (s_tdata),
        .first_tag  (first_tag_reg),
        .second_tag (second_tag_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(OUT_BYTES_W - OUT_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

// ----- rtl/nspc_core.sv -----
// sentence tag tracking and capture indexing, one byte per transaction
// depends on nspc_pkg
`default_nettype none

module nspc_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [7:0]                 rx_byte,
    input  wire logic [nspc_pkg::TAG_W-1:0] first_tag,
    input  wire logic [nspc_pkg::TAG_W-1:0] second_tag,
    output nspc_pkg::result_t               result
);
    import nspc_pkg::*;

    logic [TAG_W-9:0] shift_reg, shift_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             collecting_reg, collecting_next;
    logic             lock_reg, lock_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] index_reg, index_next;

    logic             coll_now;
    logic             take_tag;
    logic [CNT_W-1:0] count_inc;
    logic             body_now;
    logic [TAG_W-1:0] word;
    logic             tag_done;
    logic             header_now;

    always_comb
    begin
        coll_now = collecting_reg | (rx_byte == START_CHAR);
        take_tag = coll_now && (count_reg < TAG_FULL);
        count_inc = take_tag ? count_reg + 1'b1 : count_reg;
        // the completing byte is the last tag byte, the rest sit in the shift line
        word = {shift_reg, rx_byte};
        shift_next = take_tag ? {shift_reg[TAG_W-17:0], rx_byte} : shift_reg;
        body_now = lock_reg && (index_reg < CAPTURE_LIMIT);
        tag_done = (count_inc == TAG_FULL);
        header_now = 1'b0;

        count_next = count_inc;
        collecting_next = coll_now;
        lock_next = lock_reg;
        found_next = found_reg;
        index_next = body_now ? index_reg + 1'b1 : index_reg;

        if (tag_done && !lock_reg)
        begin
            collecting_next = 1'b0;
            header_now = 1'b1;
            lock_next = (word == first_tag);
            count_next = '0;
        end
        else if (tag_done && !found_reg)
        begin
            collecting_next = 1'b0;
            count_next = '0;
            if (word == second_tag)
            begin
                found_next = 1'b1;
            end
            else
            begin
                lock_next = 1'b0;
                index_next = INDEX_START;
            end
        end
    end

    always_comb
    begin
        result.body_write = body_now;
        result.body_index = body_now ? index_reg : '0;
        result.body_byte = body_now ? rx_byte : '0;
        result.header_write = header_now;
        result.header_word = header_now ? word : '0;
        result.first_locked = lock_next;
        result.second_found = found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            collecting_reg <= 1'b0;
            lock_reg <= 1'b0;
            found_reg <= 1'b0;
            index_reg <= INDEX_START;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            collecting_reg <= collecting_next;
            lock_reg <= lock_next;
            found_reg <= found_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            shift_reg <= shift_next;
        end
    end

endmodule

`default_nettype wire
